### hdl/tspc_pkg.sv
// Shared constants, types and helpers for the touch strip posture classifier.
// Depends on nothing; used by hdl/touch_strip_posture_classifier.sv and test/tb_top.sv.
package tspc_pkg;

   // Number of capacitive strips sampled per transaction.
   localparam int STRIP_COUNT = 4;
   localparam int SAMPLE_WIDTH = 16;
   localparam int THRESHOLD_WIDTH = 16;
   localparam int THRESHOLD_RESET = 50;
   localparam int POSTURE_WIDTH = 3;
   localparam int COUNT_WIDTH = $clog2(STRIP_COUNT + 1);

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_WIDTH = ((STRIP_COUNT * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_WIDTH = POSTURE_WIDTH + STRIP_COUNT;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_WIDTH + 7) / 8) * 8;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [STRIP_COUNT-1:0] mask_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic [POSTURE_WIDTH-1:0] {
      POSTURE_OFF      = 3'd0,
      POSTURE_STANDING = 3'd1,
      POSTURE_SITTING  = 3'd2,
      POSTURE_WALKING  = 3'd3,
      POSTURE_LYING    = 3'd4
   } posture_type;

   // Number of set bits in a strip mask.
   function automatic count_type ones_in(input mask_type m);
      count_type n;
      n = '0;
      for (int i = 0; i < STRIP_COUNT; i++) begin
         n = n + count_type'(m[i]);
      end
      return n;
   endfunction

endpackage

### hdl/touch_strip_posture_classifier.sv
// Touch strip posture classifier: input register, flag/posture logic, result register.
// Depends on hdl/tspc_pkg.sv.
// A request passes through the input register and then the result register before
// rsp_tvalid rises. Throughput: one transaction per cycle while rsp_tready is high;
// the input and result registers form a two-stage pipeline that advances whenever
// the result register is free or taken.
// Reset (synchronous, active high) clears the last samples, touch flags and
// valid bits, and sets the trigger threshold to 50.
module touch_strip_posture_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // Fields from bit 0 up: reading_0, reading_1, reading_2, reading_3 (16 bits each).
   input  logic [tspc_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0 up: posture (3 bits), touch_mask (4 bits), zero padding.
   output logic [tspc_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Trigger threshold write channel.
   input  logic [tspc_pkg::THRESHOLD_WIDTH-1:0] csr_data,
   input  logic                                csr_valid,
   output logic                                csr_ready
);

   logic [tspc_pkg::THRESHOLD_WIDTH-1:0] threshold_ff;
   logic [tspc_pkg::REQ_DATA_WIDTH-1:0]  in_data_ff;
   logic                                 in_valid_ff;
   tspc_pkg::sample_type                 last_sample_ff [tspc_pkg::STRIP_COUNT];
   tspc_pkg::sample_type                 last_sample_in [tspc_pkg::STRIP_COUNT];
   tspc_pkg::mask_type                   flags_ff;
   tspc_pkg::mask_type                   flags_in;
   tspc_pkg::count_type                  count;
   tspc_pkg::posture_type                posture_in;
   tspc_pkg::posture_type                posture_ff;
   tspc_pkg::mask_type                   mask_ff;
   logic                                 rsp_valid_ff;
   logic                                 advance;

   // Pipeline control: the input stage moves on when the result register can take it.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= tspc_pkg::THRESHOLD_WIDTH'(tspc_pkg::THRESHOLD_RESET);
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   // Per-strip flag update. A rise beyond the threshold sets a clear flag and a
   // fall beyond it clears a set flag; compares are done in 17 bits so the
   // threshold sum cannot wrap.
   always_comb begin
      logic [tspc_pkg::SAMPLE_WIDTH:0] sample_wide;
      logic [tspc_pkg::SAMPLE_WIDTH:0] last_wide;
      logic [tspc_pkg::SAMPLE_WIDTH:0] th_wide;
      sample_wide = '0;
      last_wide   = '0;
      th_wide     = {1'b0, threshold_ff};
      flags_in    = flags_ff;
      for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
         last_sample_in[i] = in_data_ff[i*tspc_pkg::SAMPLE_WIDTH +: tspc_pkg::SAMPLE_WIDTH];
         sample_wide = {1'b0, last_sample_in[i]};
         last_wide   = {1'b0, last_sample_ff[i]};
         if (flags_ff[i] && (last_wide > sample_wide + th_wide)) begin
            flags_in[i] = 1'b0;
         end else if (!flags_ff[i] && (sample_wide > last_wide + th_wide)) begin
            flags_in[i] = 1'b1;
         end
      end
   end

   // Posture decision from the new mask, the previous mask and the touch count.
   always_comb begin
      count = tspc_pkg::ones_in(flags_in);
      priority if (flags_in == '0) begin
         posture_in = tspc_pkg::POSTURE_OFF;
      end else if (flags_in == '1) begin
         posture_in = tspc_pkg::POSTURE_LYING;
      end else if (flags_in == flags_ff) begin
         posture_in = (count == tspc_pkg::COUNT_WIDTH'(1)) ? tspc_pkg::POSTURE_STANDING
                                                           : tspc_pkg::POSTURE_SITTING;
      end else begin
         posture_in = (count < tspc_pkg::COUNT_WIDTH'(3)) ? tspc_pkg::POSTURE_WALKING
                                                          : tspc_pkg::POSTURE_SITTING;
      end
   end

   // Strip state: last samples and touch flags advance with each transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
            last_sample_ff[i] <= '0;
         end
      end else if (advance) begin
         flags_ff <= flags_in;
         for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
            last_sample_ff[i] <= last_sample_in[i];
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         posture_ff <= posture_in;
         mask_ff    <= flags_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tspc_pkg::RSP_DATA_WIDTH - tspc_pkg::RSP_FIELD_WIDTH){1'b0}},
                        mask_ff, posture_ff};

   // The reported mask always matches the touch flags committed with it.
   a_mask_matches_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (mask_ff == flags_ff))
      else $error("result mask differs from committed flags");

   // Off is reported exactly when no strip is touched.
   a_off_iff_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((posture_ff == tspc_pkg::POSTURE_OFF) == (mask_ff == '0)))
      else $error("off posture inconsistent with mask");

   // Lying is reported only when every strip is touched.
   a_lying_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && posture_ff == tspc_pkg::POSTURE_LYING) |-> (mask_ff == '1))
      else $error("lying posture without full mask");

   // An accepted request occupies the input stage in the next cycle.
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted request lost from input stage");

endmodule

### test/tb_top.sv
// Testbench for the touch strip posture classifier: directed and random sample streams,
// threshold changes between phases, and a scoreboard that predicts every posture result.
// Depends on hdl/tspc_pkg.sv and hdl/touch_strip_posture_classifier.sv.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      tspc_pkg::posture_type posture;
      tspc_pkg::mask_type    mask;
   } posture_result_type;

   typedef enum {PRESSURE_NONE, PRESSURE_HOLD, PRESSURE_DRAIN} pressure_kind_type;

   // Scoreboard: tracks strip levels, touch flags and the threshold, and holds
   // the posture results still owed by the block.
   class posture_scoreboard;
      tspc_pkg::sample_type last_level[tspc_pkg::STRIP_COUNT];
      tspc_pkg::mask_type   flags;
      tspc_pkg::sample_type threshold;
      posture_result_type   owed_q[$];
      int                   mismatches;

      function new();
         for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
            last_level[i] = '0;
         end
         flags = '0;
         threshold = tspc_pkg::sample_type'(tspc_pkg::THRESHOLD_RESET);
         mismatches = 0;
      endfunction

      function void set_threshold(input logic [tspc_pkg::THRESHOLD_WIDTH-1:0] value);
         threshold = value;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // Work out the posture for one accepted sample transaction.
      function void note_readings(input logic [tspc_pkg::REQ_DATA_WIDTH-1:0] data);
         tspc_pkg::sample_type s;
         tspc_pkg::mask_type   next_flags;
         int                   diff;
         int                   th;
         int                   n;
         posture_result_type   r;
         next_flags = flags;
         th = int'(threshold);
         for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
            s = data[i*tspc_pkg::SAMPLE_WIDTH +: tspc_pkg::SAMPLE_WIDTH];
            diff = int'(s) - int'(last_level[i]);
            last_level[i] = s;
            if (next_flags[i] && diff < -th) begin
               next_flags[i] = 1'b0;
            end else if (!next_flags[i] && diff > th) begin
               next_flags[i] = 1'b1;
            end
         end
         n = $countones(next_flags);
         if (next_flags == '0) begin
            r.posture = tspc_pkg::POSTURE_OFF;
         end else if (next_flags == '1) begin
            r.posture = tspc_pkg::POSTURE_LYING;
         end else if (next_flags == flags) begin
            r.posture = (n == 1) ? tspc_pkg::POSTURE_STANDING : tspc_pkg::POSTURE_SITTING;
         end else begin
            r.posture = (n < 3) ? tspc_pkg::POSTURE_WALKING : tspc_pkg::POSTURE_SITTING;
         end
         r.mask = next_flags;
         flags = next_flags;
         owed_q.push_back(r);
      endfunction

      // Compare one result transaction with the oldest owed posture.
      function void check_result(input logic [tspc_pkg::RSP_DATA_WIDTH-1:0] data);
         posture_result_type                 exp;
         logic [tspc_pkg::POSTURE_WIDTH-1:0] got_posture;
         tspc_pkg::mask_type                 got_mask;
         got_posture = data[tspc_pkg::POSTURE_WIDTH-1:0];
         got_mask = data[tspc_pkg::POSTURE_WIDTH +: tspc_pkg::STRIP_COUNT];
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected result: posture %0d mask %b", got_posture, got_mask);
            end
            return;
         end
         exp = owed_q.pop_front();
         if (got_posture != exp.posture || got_mask != exp.mask) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Result mismatch: expected posture %0d mask %b, got posture %0d mask %b",
                        exp.posture, exp.mask, got_posture, got_mask);
            end
         end
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic [tspc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [tspc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [tspc_pkg::THRESHOLD_WIDTH-1:0] csr_data = '0;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;

   posture_scoreboard    sb = new();
   tspc_pkg::sample_type driven_level[tspc_pkg::STRIP_COUNT];
   int                   cycle_count = 0;
   int                   hold_requests = 0;
   int                   hold_served = 0;
   int                   hold_left = 0;
   int                   pattern_step = 0;

   touch_strip_posture_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Monitor: results are checked before the request of the same edge is noted,
   // since a result never belongs to a transaction accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            sb.note_readings(req_tdata);
         end
         if (csr_valid && csr_ready) begin
            sb.set_threshold(csr_data);
         end
      end
   end

   // Receiver: rotates through stall patterns, and holds off for a long stretch
   // whenever the stimulus asks for it.
   always @(negedge clock) begin
      pattern_step++;
      if (hold_left == 0 && hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         case ((pattern_step / 64) % 4)
            0: rsp_tready = 1'b1;
            1: rsp_tready = 1'($urandom_range(0, 1));
            2: rsp_tready = (pattern_step % 3 == 0);
            default: rsp_tready = ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   // Offer one sample transaction, starting at a falling edge, and hold it until accepted.
   task automatic send_item(input logic [tspc_pkg::REQ_DATA_WIDTH-1:0] data);
      req_tdata = data;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_levels(input tspc_pkg::sample_type r0, input tspc_pkg::sample_type r1,
                              input tspc_pkg::sample_type r2, input tspc_pkg::sample_type r3);
      driven_level[0] = r0;
      driven_level[1] = r1;
      driven_level[2] = r2;
      driven_level[3] = r3;
      send_item({r3, r2, r1, r0});
   endtask

   // Wait until every owed result has arrived, then let the pipeline settle.
   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [tspc_pkg::THRESHOLD_WIDTH-1:0] value);
      wait_idle();
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Next random sample set: mostly strips that hover within the threshold or
   // step clearly across it, with an occasional fully random sample.
   task automatic send_random_item(input bit steady);
      int th;
      int span;
      int lvl;
      int choice;
      logic [tspc_pkg::REQ_DATA_WIDTH-1:0] data;
      th = int'(sb.threshold);
      span = (th / 2 > 300) ? 300 : th / 2;
      for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
         lvl = int'(driven_level[i]);
         if (steady) begin
            choice = ($urandom_range(0, 19) == 0) ? 5 + $urandom_range(0, 4) : 0;
         end else begin
            choice = $urandom_range(0, 9);
         end
         if (choice < 5) begin
            lvl = lvl + int'($urandom_range(0, 2 * span)) - span;
         end else if (choice < 7) begin
            lvl = lvl + th + 1 + int'($urandom_range(0, 3000));
         end else if (choice < 9) begin
            lvl = lvl - th - 1 - int'($urandom_range(0, 3000));
         end else begin
            lvl = int'($urandom_range(0, 65535));
         end
         if (lvl < 0) lvl = 0;
         if (lvl > 65535) lvl = 65535;
         driven_level[i] = tspc_pkg::sample_type'(lvl);
         data[i*tspc_pkg::SAMPLE_WIDTH +: tspc_pkg::SAMPLE_WIDTH] = driven_level[i];
      end
      send_item(data);
   endtask

   // One random phase in bursts with random gaps, with an optional pressure event
   // halfway through.
   task automatic run_phase(input int count, input pressure_kind_type pressure);
      int left;
      int burst;
      int gap;
      bit steady;
      bit pressed;
      left = count;
      pressed = 1'b0;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         steady = 1'($urandom_range(0, 1));
         if (pressure == PRESSURE_HOLD && !pressed && left <= count / 2) begin
            // Long receiver hold-off while the sender keeps offering back to back.
            hold_requests++;
            burst = 40;
         end
         if (burst > left) burst = left;
         repeat (burst) send_random_item(steady);
         left -= burst;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (pressure != PRESSURE_NONE && !pressed && left <= count / 2) begin
            pressed = 1'b1;
            if (pressure == PRESSURE_DRAIN) begin
               req_tvalid = 1'b0;
               wait_idle();
               gap = 0;
            end
         end
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < tspc_pkg::STRIP_COUNT; i++) begin
         driven_level[i] = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset threshold: first step, all strips, each
      // strip leaving in turn, and the exact threshold boundary.
      send_levels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_levels(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_levels(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_levels(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_levels(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
      send_levels(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_levels(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_levels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'd50, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'd101, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'd51, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'd0, 16'h0000, 16'h0000, 16'h0000);
      req_tvalid = 1'b0;

      // Zero threshold: any strict rise sets a clear flag and any strict fall clears a set flag.
      write_threshold(16'd0);
      send_levels(16'd1, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'd1, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'd0, 16'h0000, 16'h0000, 16'h0000);
      send_levels(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_levels(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      req_tvalid = 1'b0;

      // Maximum threshold: no flag can change any more.
      write_threshold(16'hFFFF);
      send_levels(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      send_levels(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      req_tvalid = 1'b0;

      // Random phases over a spread of thresholds.
      write_threshold(16'd50);
      run_phase(180, PRESSURE_NONE);
      write_threshold(16'd0);
      run_phase(180, PRESSURE_HOLD);
      write_threshold(16'hFFFF);
      run_phase(120, PRESSURE_NONE);
      write_threshold(16'd1);
      run_phase(180, PRESSURE_DRAIN);
      write_threshold(16'd1000);
      run_phase(200, PRESSURE_HOLD);
      write_threshold(16'($urandom_range(0, 65535)));
      run_phase(180, PRESSURE_NONE);
      write_threshold(16'd30000);
      run_phase(180, PRESSURE_DRAIN);
      write_threshold(16'($urandom_range(0, 500)));
      run_phase(210, PRESSURE_NONE);

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
hdl/tspc_pkg.sv
hdl/touch_strip_posture_classifier.sv
test/tb_top.sv
